FILE: rtl/core/fba_pkg.sv
// Shared types and constants of the frame bitmap allocator.
package fba_pkg;

	localparam int MODE_W   = 2;
	localparam int FRAME_W  = 12;
	localparam int ADDR_W   = 24;
	localparam int STATUS_W = 2;
	localparam int WORD_W   = 32;
	localparam int BIT_W    = 5;
	localparam int FRAME_LIMIT = 4096;

	localparam logic [WORD_W-1:0] FULL_WORD = 32'hffff_ffff;

	localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TEST  = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_MAPPED = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd3;

	typedef enum logic [2:0] {
		RES_NONE   = 3'd0,
		RES_MAPPED = 3'd1,
		RES_FULL   = 3'd2,
		RES_ALLOC  = 3'd3,
		RES_FREED  = 3'd4,
		RES_ABSENT = 3'd5,
		RES_TEST   = 3'd6
	} res_kind_t;

	typedef struct packed {
		logic      ld;
		logic      clr_step;
		logic      scan_step;
		logic      alloc_wr;
		logic      free_rd;
		logic      free_wr;
		logic      div;
		logic      test_rd;
		logic      res_ld;
		res_kind_t res_kind;
		logic      out_ld;
	} cmd_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              pframe_nz;
		logic              present;
		logic              scan_hit;
		logic              scan_fit;
		logic              scan_last;
		logic              clr_last;
		logic              out_free;
	} stat_t;

endpackage

FILE: rtl/core/fba_ctrl.sv
// Sequencer of the frame bitmap allocator: clearing pass, scan, free and test steps.
module fba_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  fba_pkg::stat_t st,
	output fba_pkg::cmd_t  cmd
);
	import fba_pkg::*;

	typedef enum logic [9:0] {
		S_CLEAR    = 10'b00_0000_0001,
		S_IDLE     = 10'b00_0000_0010,
		S_DISPATCH = 10'b00_0000_0100,
		S_SCAN     = 10'b00_0000_1000,
		S_FREE_RD  = 10'b00_0001_0000,
		S_FREE_WR  = 10'b00_0010_0000,
		S_TEST_DIV = 10'b00_0100_0000,
		S_TEST_RD  = 10'b00_1000_0000,
		S_TEST_BIT = 10'b01_0000_0000,
		S_RESP     = 10'b10_0000_0000
	} state_t;

	state_t state_q, state_d;

	assign req_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.res_kind = RES_NONE;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (st.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.ld  = 1'b1;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				unique case (st.mode)
					MODE_ALLOC: begin
						if (st.pframe_nz) begin
							cmd.res_ld   = 1'b1;
							cmd.res_kind = RES_MAPPED;
							state_d      = S_RESP;
						end else begin
							state_d = S_SCAN;
						end
					end
					MODE_FREE: begin
						if (!st.present) begin
							cmd.res_ld   = 1'b1;
							cmd.res_kind = RES_ABSENT;
							state_d      = S_RESP;
						end else begin
							state_d = S_FREE_RD;
						end
					end
					MODE_TEST: state_d = S_TEST_DIV;
					default: begin
						cmd.res_ld   = 1'b1;
						cmd.res_kind = RES_NONE;
						state_d      = S_RESP;
					end
				endcase
			end
			S_SCAN: begin
				if (st.scan_hit) begin
					cmd.res_ld = 1'b1;
					if (st.scan_fit) begin
						cmd.alloc_wr = 1'b1;
						cmd.res_kind = RES_ALLOC;
					end else begin
						cmd.res_kind = RES_FULL;
					end
					state_d = S_RESP;
				end else if (st.scan_last) begin
					cmd.res_ld   = 1'b1;
					cmd.res_kind = RES_FULL;
					state_d      = S_RESP;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_FREE_RD: begin
				cmd.free_rd = 1'b1;
				state_d     = S_FREE_WR;
			end
			S_FREE_WR: begin
				cmd.free_wr  = 1'b1;
				cmd.res_ld   = 1'b1;
				cmd.res_kind = RES_FREED;
				state_d      = S_RESP;
			end
			S_TEST_DIV: begin
				cmd.div = 1'b1;
				state_d = S_TEST_RD;
			end
			S_TEST_RD: begin
				cmd.test_rd = 1'b1;
				state_d     = S_TEST_BIT;
			end
			S_TEST_BIT: begin
				cmd.res_ld   = 1'b1;
				cmd.res_kind = RES_TEST;
				state_d      = S_RESP;
			end
			S_RESP: begin
				if (st.out_free) begin
					cmd.out_ld = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLEAR;
		else state_q <= state_d;
	end

	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> (state_q == S_DISPATCH))
		else $error("accepted item not dispatched");

	a_write_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clr_step, cmd.alloc_wr, cmd.free_wr}))
		else $error("more than one bitmap write source");

	a_out_after_res: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |-> $past(state_q) == S_RESP || $past(cmd.res_ld))
		else $error("result sent without being formed");

endmodule

FILE: rtl/core/fba_dp.sv
// Datapath of the frame bitmap allocator: bitmap memory, scan counter, divider and result.
module fba_dp #(
	parameter int NUM_FRAMES = 4096,
	parameter int PAGE_BYTES = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  fba_pkg::cmd_t                  cmd,
	output fba_pkg::stat_t                 st,
	input  logic [fba_pkg::MODE_W-1:0]     mode,
	input  logic [fba_pkg::FRAME_W-1:0]    page_frame,
	input  logic                           page_present,
	input  logic                           user_flag,
	input  logic                           write_flag,
	input  logic [fba_pkg::ADDR_W-1:0]     address,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output logic [fba_pkg::STATUS_W-1:0]   status,
	output logic [fba_pkg::FRAME_W-1:0]    new_frame,
	output logic                           entry_present,
	output logic                           entry_user,
	output logic                           entry_write,
	output logic                           frame_used
);
	import fba_pkg::*;

	localparam int WORDS       = (NUM_FRAMES + 31) / 32;
	localparam int IDX_W       = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int CNT_W       = IDX_W + 1;
	localparam int ALLOC_LIMIT = (NUM_FRAMES < FRAME_LIMIT) ? NUM_FRAMES : FRAME_LIMIT;
	localparam int ALLOC_WORDS = (ALLOC_LIMIT + 31) / 32;
	localparam int RECIP_W     = 26;
	localparam int SHIFT       = ADDR_W + $clog2(PAGE_BYTES);
	localparam int PROD_W      = ADDR_W + RECIP_W;
	localparam longint unsigned RECIP =
		((64'd1 << SHIFT) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES);
	localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(RECIP);

	logic [WORD_W-1:0]   mem [0:WORDS-1];
	logic [WORD_W-1:0]   rd_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic                rv_s1;

	logic [MODE_W-1:0]   mode_q;
	logic [FRAME_W-1:0]  pframe_q;
	logic                present_q;
	logic                user_q;
	logic                write_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [ADDR_W-1:0]   quot_q;
	logic [CNT_W-1:0]    cnt_q;

	logic [STATUS_W-1:0] res_status_q;
	logic [FRAME_W-1:0]  res_frame_q;
	logic                res_present_q;
	logic                res_user_q;
	logic                res_write_q;
	logic                res_used_q;
	logic                rsp_valid_q;

	logic [IDX_W-1:0]    pf_idx;
	logic [IDX_W-1:0]    q_idx;
	logic [IDX_W-1:0]    rd_addr;
	logic [IDX_W-1:0]    wr_addr;
	logic [WORD_W-1:0]   wr_data;
	logic                wr_en;
	logic [BIT_W-1:0]    free_bit;
	logic [31:0]         hit_frame;
	logic                pf_in_range;
	logic                q_in_range;
	logic [PROD_W-1:0]   prod;

	assign pf_idx      = IDX_W'(pframe_q >> BIT_W);
	assign q_idx       = IDX_W'(quot_q >> BIT_W);
	assign pf_in_range = (32'(pframe_q) < 32'(NUM_FRAMES));
	assign q_in_range  = (32'(quot_q) < 32'(NUM_FRAMES));
	assign prod        = PROD_W'(addr_q) * PROD_W'(RECIP_V);

	always_comb begin
		free_bit = BIT_W'(WORD_W - 1);
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (!rd_s1[i]) free_bit = BIT_W'(i);
		end
	end

	assign hit_frame = 32'({idx_s1, free_bit});

	always_comb begin
		rd_addr = cnt_q[IDX_W-1:0];
		if (cmd.free_rd) rd_addr = pf_idx;
		else if (cmd.test_rd) rd_addr = q_idx;
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cnt_q[IDX_W-1:0];
		wr_data = '0;
		if (cmd.clr_step) begin
			wr_en = 1'b1;
		end else if (cmd.alloc_wr) begin
			wr_en   = 1'b1;
			wr_addr = idx_s1;
			wr_data = rd_s1 | (WORD_W'(1) << free_bit);
		end else if (cmd.free_wr) begin
			wr_en   = pf_in_range;
			wr_addr = pf_idx;
			wr_data = rd_s1 & ~(WORD_W'(1) << pframe_q[BIT_W-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_s1  <= mem[rd_addr];
		idx_s1 <= cnt_q[IDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rv_s1 <= 1'b0;
		end else if (cmd.ld) begin
			cnt_q <= '0;
			rv_s1 <= 1'b0;
		end else if (cmd.clr_step || cmd.scan_step) begin
			cnt_q <= cnt_q + CNT_W'(1);
			rv_s1 <= cmd.scan_step && (cnt_q < CNT_W'(ALLOC_WORDS));
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld) begin
			mode_q    <= mode;
			pframe_q  <= page_frame;
			present_q <= page_present;
			user_q    <= user_flag;
			write_q   <= write_flag;
			addr_q    <= address;
		end
		if (cmd.div) quot_q <= ADDR_W'(prod >> SHIFT);
	end

	always_ff @(posedge clk) begin
		if (cmd.res_ld) begin
			res_status_q  <= ST_OK;
			res_frame_q   <= '0;
			res_present_q <= 1'b0;
			res_user_q    <= 1'b0;
			res_write_q   <= 1'b0;
			res_used_q    <= 1'b0;
			case (cmd.res_kind)
				RES_MAPPED: res_status_q <= ST_MAPPED;
				RES_FULL:   res_status_q <= ST_FULL;
				RES_ABSENT: res_status_q <= ST_ABSENT;
				RES_ALLOC: begin
					res_frame_q   <= hit_frame[FRAME_W-1:0];
					res_present_q <= 1'b1;
					res_user_q    <= user_q;
					res_write_q   <= write_q;
				end
				RES_TEST: res_used_q <= q_in_range && rd_s1[quot_q[BIT_W-1:0]];
				default: res_status_q <= ST_OK;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			status        <= res_status_q;
			new_frame     <= res_frame_q;
			entry_present <= res_present_q;
			entry_user    <= res_user_q;
			entry_write   <= res_write_q;
			frame_used    <= res_used_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rsp_valid_q <= 1'b0;
		else if (cmd.out_ld) rsp_valid_q <= 1'b1;
		else if (!rsp_stall) rsp_valid_q <= 1'b0;
	end

	assign rsp_valid = rsp_valid_q;

	assign st.mode      = mode_q;
	assign st.pframe_nz = (pframe_q != '0);
	assign st.present   = present_q;
	assign st.scan_hit  = rv_s1 && (rd_s1 != FULL_WORD);
	assign st.scan_fit  = (hit_frame < 32'(ALLOC_LIMIT));
	assign st.scan_last = rv_s1 && (idx_s1 == IDX_W'(ALLOC_WORDS - 1));
	assign st.clr_last  = (cnt_q == CNT_W'(WORDS - 1));
	assign st.out_free  = !rsp_valid_q || !rsp_stall;

	a_alloc_free_bit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.alloc_wr |-> rv_s1 && !rd_s1[free_bit] && (hit_frame < 32'(ALLOC_LIMIT)))
		else $error("allocation marks a frame that was not free");

	a_out_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |-> (!rsp_valid_q || !rsp_stall))
		else $error("result overwrites an item not yet taken");

	a_refusal_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && status != ST_OK) |-> (!entry_present && new_frame == '0
			&& !frame_used))
		else $error("refusal carries entry fields");

	a_used_only_test: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && frame_used) |-> (!entry_present && status == ST_OK))
		else $error("frame bit reported outside test");

endmodule

FILE: rtl/core/frame_bitmap_allocator.sv
// Top level of the frame bitmap allocator: sequencer plus bitmap datapath.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+------------------------------------------------
//  request | req_valid | req_stall | mode page_frame page_present user_flag
//          |           |           | write_flag address
//  result  | rsp_valid | rsp_stall | status new_frame entry_present entry_user
//          |           |           | entry_write frame_used
//
// Allocate scans 1 to 128 bitmap words at 4096 frames, reading one word a cycle
// from the bitmap memory, which has a separate read port and write port.
// Free reads and rewrites a word; test divides, reads and checks a bit; a refused item
// or unused mode answers directly. After reset a clearing pass writes (NUM_FRAMES+31)/32
// words, one a cycle, while req_stall stays high.
// A held result does not block the next item; a finished item waits in its result
// register until the output slot frees.
module frame_bitmap_allocator #(
	parameter int NUM_FRAMES = 4096,
	parameter int PAGE_BYTES = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic [fba_pkg::MODE_W-1:0]    mode,
	input  logic [fba_pkg::FRAME_W-1:0]   page_frame,
	input  logic                          page_present,
	input  logic                          user_flag,
	input  logic                          write_flag,
	input  logic [fba_pkg::ADDR_W-1:0]    address,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic [fba_pkg::STATUS_W-1:0]  status,
	output logic [fba_pkg::FRAME_W-1:0]   new_frame,
	output logic                          entry_present,
	output logic                          entry_user,
	output logic                          entry_write,
	output logic                          frame_used
);
	import fba_pkg::*;

	cmd_t  cmd;
	stat_t st;

	fba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.st        (st),
		.cmd       (cmd)
	);

	fba_dp #(
		.NUM_FRAMES (NUM_FRAMES),
		.PAGE_BYTES (PAGE_BYTES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.mode          (mode),
		.page_frame    (page_frame),
		.page_present  (page_present),
		.user_flag     (user_flag),
		.write_flag    (write_flag),
		.address       (address),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.status        (status),
		.new_frame     (new_frame),
		.entry_present (entry_present),
		.entry_user    (entry_user),
		.entry_write   (entry_write),
		.frame_used    (frame_used)
	);

endmodule

FILE: sim/frame_bitmap_allocator_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the frame bitmap allocator: directed and random runs.
import fba_pkg::*;

typedef struct packed {
	logic [MODE_W-1:0]  mode;
	logic [FRAME_W-1:0] page_frame;
	logic               page_present;
	logic               user_flag;
	logic               write_flag;
	logic [ADDR_W-1:0]  address;
} frame_request_t;

typedef struct packed {
	logic [STATUS_W-1:0] status;
	logic [FRAME_W-1:0]  new_frame;
	logic                entry_present;
	logic                entry_user;
	logic                entry_write;
	logic                frame_used;
} frame_answer_t;

class bitmap_mirror #(int FRAMES = 4096, int PAGE = 4096);
	localparam int WORDS = (FRAMES + WORD_W - 1) / WORD_W;
	localparam int ALLOC_TOP = (FRAMES < FRAME_LIMIT) ? FRAMES : FRAME_LIMIT;

	logic [WORD_W-1:0] used_words [WORDS];
	frame_answer_t     owed [$];
	int                errors;

	function new();
		foreach (used_words[i]) used_words[i] = '0;
		errors = 0;
	endfunction

	function automatic logic frame_bit(int unsigned f);
		if (f >= FRAMES) return 1'b0;
		return used_words[f / WORD_W][f % WORD_W];
	endfunction

	function automatic void frame_mark(int unsigned f, logic used);
		if (f < FRAMES) used_words[f / WORD_W][f % WORD_W] = used;
	endfunction

	function automatic frame_answer_t note_request(frame_request_t r);
		frame_answer_t a;
		int unsigned f;
		a = '0;
		f = 0;
		case (r.mode)
			MODE_ALLOC: begin
				if (r.page_frame != '0) begin
					a.status = ST_MAPPED;
				end else begin
					while (f < ALLOC_TOP && frame_bit(f)) f++;
					if (f >= ALLOC_TOP) begin
						a.status = ST_FULL;
					end else begin
						frame_mark(f, 1'b1);
						a.status = ST_OK;
						a.new_frame = FRAME_W'(f);
						a.entry_present = 1'b1;
						a.entry_user = r.user_flag;
						a.entry_write = r.write_flag;
					end
				end
			end
			MODE_FREE: begin
				if (!r.page_present) begin
					a.status = ST_ABSENT;
				end else begin
					frame_mark(32'(r.page_frame), 1'b0);
					a.status = ST_OK;
				end
			end
			MODE_TEST: begin
				a.frame_used = frame_bit(r.address / PAGE);
			end
			default: begin
			end
		endcase
		owed.push_back(a);
		return a;
	endfunction

	function automatic void check_answer(frame_answer_t got);
		frame_answer_t want;
		if (owed.size() == 0) begin
			$display("%0t: unexpected answer status %0d new_frame %0d", $time, got.status,
				got.new_frame);
			errors++;
			return;
		end
		want = owed.pop_front();
		if (got.status !== want.status) begin
			$display("%0t: status expected %0d got %0d", $time, want.status, got.status);
			errors++;
		end
		if (got.new_frame !== want.new_frame) begin
			$display("%0t: new_frame expected %0d got %0d", $time, want.new_frame,
				got.new_frame);
			errors++;
		end
		if (got.entry_present !== want.entry_present) begin
			$display("%0t: entry_present expected %0b got %0b", $time, want.entry_present,
				got.entry_present);
			errors++;
		end
		if (got.entry_user !== want.entry_user) begin
			$display("%0t: entry_user expected %0b got %0b", $time, want.entry_user,
				got.entry_user);
			errors++;
		end
		if (got.entry_write !== want.entry_write) begin
			$display("%0t: entry_write expected %0b got %0b", $time, want.entry_write,
				got.entry_write);
			errors++;
		end
		if (got.frame_used !== want.frame_used) begin
			$display("%0t: frame_used expected %0b got %0b", $time, want.frame_used,
				got.frame_used);
			errors++;
		end
	endfunction

	function automatic int outstanding();
		return owed.size();
	endfunction
endclass

module frame_bitmap_allocator_test;
	localparam int NUM_FRAMES = 4096;
	localparam int PAGE_BYTES = 4096;
	localparam int RANDOM_ITEMS = 1700;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 200;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	typedef enum {STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_PERIODIC} stall_pattern_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_stall;
	logic [MODE_W-1:0]   mode = '0;
	logic [FRAME_W-1:0]  page_frame = '0;
	logic                page_present = 1'b0;
	logic                user_flag = 1'b0;
	logic                write_flag = 1'b0;
	logic [ADDR_W-1:0]   address = '0;
	logic                rsp_valid;
	logic                rsp_stall = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [FRAME_W-1:0]  new_frame;
	logic                entry_present;
	logic                entry_user;
	logic                entry_write;
	logic                frame_used;

	bitmap_mirror #(NUM_FRAMES, PAGE_BYTES) mirror;
	int unsigned   held_frames [$];
	frame_answer_t last_answer;
	int            burst_left = 0;
	int            holds_asked = 0;
	int            idle_cycles = 0;

	frame_bitmap_allocator #(
		.NUM_FRAMES(NUM_FRAMES),
		.PAGE_BYTES(PAGE_BYTES)
	) DUT (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic frame_request_t compose(logic [MODE_W-1:0] m, int unsigned pf, logic pp,
			logic uf, logic wf, logic [ADDR_W-1:0] ad);
		frame_request_t r;
		r.mode = m;
		r.page_frame = FRAME_W'(pf);
		r.page_present = pp;
		r.user_flag = uf;
		r.write_flag = wf;
		r.address = ad;
		return r;
	endfunction

	task automatic pace_sender();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
		gap = $urandom_range(1, 10);
		req_valid <= 1'b0;
		repeat (gap) @(posedge clk);
	endtask

	task automatic send_request(input frame_request_t r);
		req_valid <= 1'b1;
		mode <= r.mode;
		page_frame <= r.page_frame;
		page_present <= r.page_present;
		user_flag <= r.user_flag;
		write_flag <= r.write_flag;
		address <= r.address;
		do @(posedge clk); while (req_stall !== 1'b0);
		last_answer = mirror.note_request(r);
		if (r.mode == MODE_ALLOC && last_answer.status == ST_OK)
			held_frames.push_back(32'(last_answer.new_frame));
		pace_sender();
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		do @(posedge clk); while (mirror.outstanding() != 0);
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_valid === 1'b1 && !rsp_stall)
			mirror.check_answer({status, new_frame, entry_present, entry_user, entry_write,
				frame_used});
	end

	always @(posedge clk) begin
		if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
		$display("Verification failed");
		$finish;
	end

	initial begin
		stall_pattern_t kind;
		int span;
		int holds_done;
		int tick;
		holds_done = 0;
		tick = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (holds_asked > holds_done) begin
				holds_done++;
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			kind = stall_pattern_t'($urandom_range(0, 3));
			span = $urandom_range(10, 150);
			repeat (span) begin
				case (kind)
					STALL_NONE: rsp_stall <= 1'b0;
					STALL_COIN: rsp_stall <= 1'($urandom_range(0, 1));
					STALL_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 7);
					default: rsp_stall <= (tick % 3 != 0);
				endcase
				tick++;
				@(posedge clk);
			end
		end
	end

	initial begin
		int i;
		int pick;
		int k;
		int unsigned f;
		logic u;
		logic w;
		logic [ADDR_W-1:0] addr;
		mirror = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(compose(MODE_TEST, 0, 1'b0, 1'b0, 1'b0, 24'h000000));
		send_request(compose(MODE_FREE, 4095, 1'b0, 1'b1, 1'b1, 24'hffffff));
		send_request(compose(MODE_ALLOC, 4095, 1'b1, 1'b1, 1'b1, 24'hffffff));
		send_request(compose(MODE_ALLOC, 1, 1'b0, 1'b0, 1'b0, 24'h000000));
		send_request(compose(MODE_ALLOC, 0, 1'b0, 1'b0, 1'b0, 24'h000000));
		send_request(compose(MODE_ALLOC, 0, 1'b1, 1'b1, 1'b1, 24'hffffff));
		send_request(compose(MODE_ALLOC, 0, 1'b0, 1'b1, 1'b0, 24'h123456));
		send_request(compose(MODE_ALLOC, 0, 1'b1, 1'b0, 1'b1, 24'hedcba9));
		send_request(compose(MODE_TEST, 0, 1'b0, 1'b0, 1'b0, 24'h000fff));
		send_request(compose(MODE_TEST, 4095, 1'b1, 1'b1, 1'b1, 24'hffffff));
		send_request(compose(MODE_TEST, 0, 1'b0, 1'b0, 1'b0, 24'h001000));
		send_request(compose(MODE_FREE, 0, 1'b1, 1'b0, 1'b0, 24'h000000));
		send_request(compose(MODE_TEST, 0, 1'b0, 1'b0, 1'b0, 24'h000abc));
		send_request(compose(MODE_ALLOC, 0, 1'b0, 1'b1, 1'b1, 24'h000000));
		send_request(compose(MODE_FREE, 4095, 1'b1, 1'b1, 1'b1, 24'hffffff));
		send_request(compose(MODE_UNUSED, 4095, 1'b1, 1'b1, 1'b1, 24'hffffff));
		send_request(compose(MODE_UNUSED, 0, 1'b0, 1'b0, 1'b0, 24'h000000));
		send_request(compose(MODE_FREE, 2, 1'b1, 1'b1, 1'b1, 24'hffffff));
		send_request(compose(MODE_ALLOC, 0, 1'b0, 1'b0, 1'b1, 24'h000000));
		send_request(compose(MODE_TEST, 0, 1'b0, 1'b0, 1'b0, 24'h002abc));
		wait_drained();

		send_request(compose(MODE_TEST, 0, 1'b0, 1'b0, 1'b0, 24'hffffff));
		send_request(compose(MODE_FREE, 4095, 1'b1, 1'b0, 1'b0, 24'h000000));
		send_request(compose(MODE_TEST, 0, 1'b0, 1'b0, 1'b0, 24'hfff800));
		send_request(compose(MODE_ALLOC, 0, 1'b0, 1'b1, 1'b0, 24'h000000));
		send_request(compose(MODE_ALLOC, 0, 1'b1, 1'b0, 1'b1, 24'h000000));
		send_request(compose(MODE_FREE, 0, 1'b1, 1'b1, 1'b1, 24'h000000));
		send_request(compose(MODE_ALLOC, 0, 1'b0, 1'b1, 1'b1, 24'h000000));
		wait_drained();

		holds_asked++;
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 2)
				holds_asked++;
			if (i % 400 == 399)
				wait_drained();
			pick = $urandom_range(0, 99);
			u = 1'($urandom);
			w = 1'($urandom);
			addr = ADDR_W'($urandom);
			if (pick < 30 || (pick < 70 && held_frames.size() == 0)) begin
				send_request(compose(MODE_ALLOC, 0, 1'($urandom), u, w, addr));
			end else if (pick < 60) begin
				k = $urandom_range(0, held_frames.size() - 1);
				f = held_frames[k];
				held_frames.delete(k);
				send_request(compose(MODE_FREE, f, 1'b1, u, w, addr));
			end else if (pick < 70) begin
				k = $urandom_range(0, held_frames.size() - 1);
				addr = ADDR_W'(held_frames[k] * PAGE_BYTES + $urandom_range(0, PAGE_BYTES - 1));
				send_request(compose(MODE_TEST, $urandom_range(0, 4095), 1'($urandom), u, w,
					addr));
			end else if (pick < 80) begin
				send_request(compose(MODE_TEST, $urandom_range(0, 4095), 1'($urandom), u, w,
					addr));
			end else if (pick < 85) begin
				send_request(compose(MODE_ALLOC, $urandom_range(1, 4095), 1'($urandom), u, w,
					addr));
			end else if (pick < 90) begin
				send_request(compose(MODE_FREE, $urandom_range(0, 4095), 1'b0, u, w, addr));
			end else if (pick < 96) begin
				send_request(compose(MODE_FREE, $urandom_range(0, 4095), 1'b1, u, w, addr));
			end else begin
				send_request(compose(MODE_UNUSED, $urandom_range(0, 4095), 1'($urandom), u, w,
					addr));
			end
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mirror.errors == 0 && mirror.outstanding() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
